// File: rtl/cct_pkg.sv
// cct_pkg: shared widths and the controller state type for the coin
// combination counter; no dependencies
`timescale 1ns / 1ps

package cct_pkg;

  localparam int COIN_W   = 16;
  localparam int TARGET_W = 10;
  localparam int COUNT_W  = 32;
  localparam int CMP_W    = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_RDRES,
    ST_CAPT,
    ST_CLEAR
  } cct_state_t;

endpackage

// File: rtl/cct_ifs.sv
// cct_ifs: valid/ready channel interfaces for coin items, count results
// and the target register write; depends on cct_pkg
`timescale 1ns / 1ps

interface cct_coin_if;
  logic                       valid;
  logic                       ready;
  logic [cct_pkg::COIN_W-1:0] coin_value;
  logic                       coin_present;
  logic                       last_coin;

  modport source (output valid, coin_value, coin_present, last_coin, input ready);
  modport sink (input valid, coin_value, coin_present, last_coin, output ready);
endinterface

interface cct_count_if;
  logic                        valid;
  logic                        ready;
  logic [cct_pkg::COUNT_W-1:0] combination_count;

  modport source (output valid, combination_count, input ready);
  modport sink (input valid, combination_count, output ready);
endinterface

interface cct_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cct_pkg::TARGET_W-1:0] target_amount;

  modport source (output valid, target_amount, input ready);
  modport sink (input valid, target_amount, output ready);
endinterface

// File: rtl/coin_combination_counter.sv
// coin_combination_counter: top level, joins the sequencer and the count
// table; depends on cct_pkg, cct_ifs, cct_table and cct_ctrl
`timescale 1ns / 1ps

// Counts the unordered combinations of coins, each usable any number of
// times, that sum to target_amount (clamped to MAX_AMOUNT), modulo 2^32. A
// coin c under effective target t walks the table over amounts c to t,
// reading two entries and writing one per cycle through its single write
// port, then does the last write-back in a flush state. A coin that is
// zero, above the target or absent skips the walk. A last item then reads
// the result in the read and capture states, held while an earlier count
// waits on the result channel, plus a clearing sweep over amounts 0 up to
// the largest target used in the set, one entry per cycle. After reset the
// block sweeps all MAX_AMOUNT + 1 entries before it accepts an item; target
// writes are taken at any time and must only be made while idle.

module coin_combination_counter #(
  parameter int MAX_AMOUNT = 1023
) (
  input  logic        clk,
  input  logic        rst,
  cct_coin_if.sink    coins,
  cct_count_if.source result,
  cct_cfg_if.sink     cfg
);

  localparam int DEPTH = MAX_AMOUNT + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [cct_pkg::COUNT_W-1:0] wr_data;
  logic [AW-1:0]               rd_addr_a;
  logic [AW-1:0]               rd_addr_b;
  logic [cct_pkg::COUNT_W-1:0] rd_data_a;
  logic [cct_pkg::COUNT_W-1:0] rd_data_b;

  cct_ctrl #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .coins     (coins),
    .result    (result),
    .cfg       (cfg),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  cct_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

// File: rtl/cct_table.sv
// cct_table: count table memory, one write port and two registered read
// ports; depends on cct_pkg
`timescale 1ns / 1ps

module cct_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [cct_pkg::COUNT_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr_a,
  input  logic [AW-1:0]               rd_addr_b,
  output logic [cct_pkg::COUNT_W-1:0] rd_data_a,
  output logic [cct_pkg::COUNT_W-1:0] rd_data_b
);

  logic [cct_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: rtl/cct_ctrl.sv
// cct_ctrl: sequencer, read-modify-write datapath with forwarding, target
// register and result register; depends on cct_pkg and cct_ifs
`timescale 1ns / 1ps

module cct_ctrl #(
  parameter int MAX_AMOUNT = 1023,
  parameter int AW         = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  cct_coin_if.sink                    coins,
  cct_count_if.source                 result,
  cct_cfg_if.sink                     cfg,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [cct_pkg::COUNT_W-1:0] wr_data,
  output logic [AW-1:0]               rd_addr_a,
  output logic [AW-1:0]               rd_addr_b,
  input  logic [cct_pkg::COUNT_W-1:0] rd_data_a,
  input  logic [cct_pkg::COUNT_W-1:0] rd_data_b
);

  localparam logic [cct_pkg::CMP_W-1:0] MAX_L  = cct_pkg::CMP_W'(MAX_AMOUNT);
  localparam logic [AW-1:0]             MAX_A  = AW'(MAX_AMOUNT);
  localparam logic [AW-1:0]             ONE_A  = AW'(1);

  cct_pkg::cct_state_t state, state_next;

  logic [cct_pkg::TARGET_W-1:0] target;
  logic [AW-1:0]                t_r;
  logic [AW-1:0]                coin_r;
  logic                         last_r;
  logic [AW-1:0]                hi;
  logic [AW-1:0]                lo;
  logic [AW-1:0]                hw;
  logic [AW-1:0]                clr_addr;
  logic                         pend;
  logic [AW-1:0]                pend_addr;
  logic                         fwd;
  logic [cct_pkg::COUNT_W-1:0]  fwd_data;
  logic                         out_valid;
  logic [cct_pkg::COUNT_W-1:0]  out_data;

  logic [cct_pkg::CMP_W-1:0]    tgt_ext;
  logic [cct_pkg::CMP_W-1:0]    tgt_eff;
  logic [AW-1:0]                t_new;
  logic                         accept;
  logic                         active;
  logic [cct_pkg::COUNT_W-1:0]  sum;
  logic [cct_pkg::COUNT_W-1:0]  clr_val;

  assign tgt_ext = cct_pkg::CMP_W'(target);
  assign tgt_eff = (tgt_ext > MAX_L) ? MAX_L : tgt_ext;
  assign t_new   = tgt_eff[AW-1:0];
  assign accept  = coins.valid && coins.ready;
  assign active  = coins.coin_present && (coins.coin_value != '0)
                   && (cct_pkg::CMP_W'(coins.coin_value) <= tgt_eff);
  assign sum     = rd_data_a + (fwd ? fwd_data : rd_data_b);
  assign clr_val = (clr_addr == '0) ? cct_pkg::COUNT_W'(1) : '0;

  assign cfg.ready                = 1'b1;
  assign result.valid             = out_valid;
  assign result.combination_count = out_data;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cct_pkg::ST_IDLE: begin
        if (accept && active) begin
          state_next = cct_pkg::ST_WALK;
        end else if (accept && coins.last_coin) begin
          state_next = cct_pkg::ST_RDRES;
        end
      end
      cct_pkg::ST_WALK: begin
        if (hi == t_r) begin
          state_next = cct_pkg::ST_FLUSH;
        end
      end
      cct_pkg::ST_FLUSH: begin
        state_next = last_r ? cct_pkg::ST_RDRES : cct_pkg::ST_IDLE;
      end
      cct_pkg::ST_RDRES: begin
        if (!out_valid || result.ready) begin
          state_next = cct_pkg::ST_CAPT;
        end
      end
      cct_pkg::ST_CAPT: begin
        state_next = cct_pkg::ST_CLEAR;
      end
      cct_pkg::ST_CLEAR: begin
        if (clr_addr == hw) begin
          state_next = cct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cct_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    coins.ready = (state == cct_pkg::ST_IDLE);
    rd_addr_a   = (state == cct_pkg::ST_WALK) ? hi : t_r;
    rd_addr_b   = lo;
    if (state == cct_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = clr_val;
    end else begin
      wr_en   = pend;
      wr_addr = pend_addr;
      wr_data = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cct_pkg::ST_CLEAR;
      target    <= '0;
      hw        <= MAX_A;
      clr_addr  <= '0;
      pend      <= 1'b0;
      fwd       <= 1'b0;
      out_valid <= 1'b0;
      last_r    <= 1'b0;
      t_r       <= '0;
      hi        <= '0;
      lo        <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        target <= cfg.target_amount;
      end
      if (accept) begin
        t_r    <= t_new;
        last_r <= coins.last_coin;
        hi     <= coins.coin_value[AW-1:0];
        lo     <= '0;
        if (active && (t_new > hw)) begin
          hw <= t_new;
        end
      end else if (state == cct_pkg::ST_WALK) begin
        hi <= hi + ONE_A;
        lo <= lo + ONE_A;
      end
      if (state == cct_pkg::ST_CLEAR) begin
        if (clr_addr == hw) begin
          clr_addr <= '0;
          hw       <= '0;
        end else begin
          clr_addr <= clr_addr + ONE_A;
        end
      end
      // write-back in the cycle after the read, bypass when reading the entry in flight
      pend <= (state == cct_pkg::ST_WALK);
      fwd  <= (state == cct_pkg::ST_WALK) && wr_en && (wr_addr == lo);
      if (state == cct_pkg::ST_CAPT) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coin_r <= coins.coin_value[AW-1:0];
    end
    pend_addr <= hi;
    fwd_data  <= wr_data;
    if (state == cct_pkg::ST_CAPT) begin
      out_data <= rd_data_a;
    end
  end

  a_walk_offset: assert property (@(posedge clk) disable iff (rst)
    state == cct_pkg::ST_WALK |-> (hi - lo) == coin_r)
    else $error("walk addresses lost their coin offset");

  a_fwd_unit_coin: assert property (@(posedge clk) disable iff (rst)
    fwd |-> coin_r == ONE_A)
    else $error("bypass taken for a coin other than one");

  a_no_pend_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == cct_pkg::ST_CLEAR |-> !pend)
    else $error("walk write-back overlaps table clear");

  a_result_from_capture: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == cct_pkg::ST_CAPT)
    else $error("result raised outside capture");

endmodule

// File: tb/coin_combination_counter_tb.sv
// coin_combination_counter_tb: directed and random coin sets checked against a
// predicting count table, with random idling and a long result hold-off
// depends on cct_pkg, cct_ifs and coin_combination_counter
`timescale 1ns / 1ps

module coin_combination_counter_tb;

  localparam int MAX_AMOUNT     = 1023;
  localparam int DRAIN_WAIT     = 2 * (MAX_AMOUNT + 8);
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 12000;

  logic clk;
  logic rst;

  cct_coin_if  coins_if ();
  cct_count_if result_if ();
  cct_cfg_if   cfg_if ();

  coin_combination_counter #(.MAX_AMOUNT(MAX_AMOUNT)) DUT (
    .clk   (clk),
    .rst   (rst),
    .coins (coins_if),
    .result(result_if),
    .cfg   (cfg_if)
  );

  logic [cct_pkg::COUNT_W-1:0] ways_to [0:MAX_AMOUNT];
  logic [cct_pkg::COUNT_W-1:0] pending_counts [$];
  int unsigned                 target_now;
  int                          errors = 0;
  int                          idle_cycles = 0;
  bit                          calm = 1'b0;
  bit                          hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_ways();
    for (int w = 0; w <= MAX_AMOUNT; w++) ways_to[w] = '0;
    ways_to[0] = 1;
  endfunction

  function automatic void tally_coin(logic [cct_pkg::COIN_W-1:0] coin, logic present,
                                     logic last);
    int t;
    t = (target_now > MAX_AMOUNT) ? MAX_AMOUNT : int'(target_now);
    if (present && coin != 0 && int'(coin) <= t) begin
      for (int w = int'(coin); w <= t; w++) begin
        ways_to[w] = ways_to[w] + ways_to[w - int'(coin)];
      end
    end
    if (last) begin
      pending_counts.push_back(ways_to[t]);
      clear_ways();
    end
  endfunction

  task automatic report_mismatch(string what, logic [cct_pkg::COUNT_W-1:0] got,
                                 logic [cct_pkg::COUNT_W-1:0] want);
    errors++;
    $display("mismatch on %s: got %0d, expected %0d, at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : count_check
    logic [cct_pkg::COUNT_W-1:0] want;
    if (rst) begin
      target_now = 0;
      clear_ways();
      pending_counts.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) target_now = 32'(cfg_if.target_amount);
      if (coins_if.valid && coins_if.ready) begin
        tally_coin(coins_if.coin_value, coins_if.coin_present, coins_if.last_coin);
      end
      if (result_if.valid && result_if.ready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch("unexpected item", result_if.combination_count, '0);
        end else begin
          want = pending_counts.pop_front();
          if (result_if.combination_count !== want) begin
            report_mismatch("combination_count", result_if.combination_count, want);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (coins_if.valid && coins_if.ready) || (result_if.valid && result_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : count_sink
    int unsigned stall;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 16);
        result_if.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_coin(logic [cct_pkg::COIN_W-1:0] coin, logic present, logic last);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      coins_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coins_if.valid        <= 1'b1;
    coins_if.coin_value   <= coin;
    coins_if.coin_present <= present;
    coins_if.last_coin    <= last;
    do @(posedge clk); while (!coins_if.ready);
  endtask

  // the block may still be walking or clearing after the last count
  task automatic wait_drained();
    coins_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_target(int unsigned amount);
    cfg_if.valid         <= 1'b1;
    cfg_if.target_amount <= amount[cct_pkg::TARGET_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_target();
    send_coin(16'h0000, 1'b0, 1'b1);
    send_coin(16'd5, 1'b1, 1'b1);
  endtask

  task automatic test_overflow();
    wait_drained();
    write_target(MAX_AMOUNT);
    for (int c = 1; c <= 12; c++) send_coin(c[cct_pkg::COIN_W-1:0], 1'b1, c == 12);
  endtask

  task automatic test_odd_coins();
    wait_drained();
    write_target(9);
    send_coin(16'd0, 1'b1, 1'b0);
    send_coin(16'hFFFF, 1'b1, 1'b0);
    send_coin(16'd10, 1'b1, 1'b0);
    send_coin(16'd3, 1'b0, 1'b0);
    send_coin(16'd2, 1'b1, 1'b0);
    send_coin(16'd3, 1'b1, 1'b1);
  endtask

  task automatic test_target_change();
    wait_drained();
    write_target(20);
    send_coin(16'd1, 1'b1, 1'b0);
    send_coin(16'd4, 1'b1, 1'b0);
    wait_drained();
    write_target(30);
    send_coin(16'd7, 1'b1, 1'b1);
  endtask

  task automatic test_empty_set();
    wait_drained();
    write_target(15);
    send_coin(16'hFFFF, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_target(8);
    hold_req = 1'b1;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < 3; i++) begin
        send_coin(cct_pkg::COIN_W'($urandom_range(1, 8)), 1'b1, i == 2);
      end
    end
  endtask

  task automatic run_random_phase(int unsigned amount, int n_items);
    int                         sent;
    int unsigned                set_len;
    int unsigned                pick;
    logic [cct_pkg::COIN_W-1:0] coin;
    logic                       present;
    wait_drained();
    write_target(amount);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        send_coin(cct_pkg::COIN_W'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b1);
        sent++;
      end else begin
        set_len = $urandom_range(1, 8);
        for (int i = 0; i < set_len; i++) begin
          pick    = $urandom_range(0, 99);
          present = 1'b1;
          if (pick < 75) begin
            coin = cct_pkg::COIN_W'($urandom_range(1, (amount > 0) ? amount : 1));
          end else if (pick < 82) begin
            coin = '0;
          end else if (pick < 88) begin
            coin = cct_pkg::COIN_W'($urandom_range(amount + 1, 16'hFFFF));
          end else if (pick < 94) begin
            coin    = cct_pkg::COIN_W'($urandom_range(0, 16'hFFFF));
            present = 1'b0;
          end else begin
            coin = cct_pkg::COIN_W'($urandom_range(0, 16'hFFFF));
          end
          send_coin(coin, present, i == set_len - 1);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_sets();
    run_random_phase(0, 60);
    run_random_phase(1, 60);
    run_random_phase(MAX_AMOUNT, 12);
    run_random_phase($urandom_range(2, 15), 130);
    run_random_phase($urandom_range(16, 63), 100);
    run_random_phase($urandom_range(64, 300), 60);
  endtask

  // no idling on either side
  task automatic test_calm_stream();
    wait_drained();
    calm = 1'b1;
    run_random_phase($urandom_range(2, 40), 120);
  endtask

  initial begin
    rst                   <= 1'b1;
    coins_if.valid        <= 1'b0;
    coins_if.coin_value   <= '0;
    coins_if.coin_present <= 1'b0;
    coins_if.last_coin    <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.target_amount  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_target();
    test_overflow();
    test_odd_coins();
    test_target_change();
    test_empty_set();
    test_backpressure();
    test_random_sets();
    test_calm_stream();

    wait_drained();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
